// ===== design/dsmfs_pkg.sv =====
// dsmfs_pkg: shared types and constants for the depth splat min filter shade unit
// no dependencies; used by the top level and dsmfs_shade by scoped names
`default_nettype none

package dsmfs_pkg;

  // default sizes
  localparam int DEF_MAX_POINT_SIZE = 7;
  localparam int DEF_MAX_ROW_LENGTH = 2048;

  // frame size saturation and row counter limit
  localparam int FRAME_LIMIT = 2048;
  localparam logic [10:0] ROW_HOLD = 11'd2047;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_COLOR_MODE   = 3'd0,
    CFG_FRAME_WIDTH  = 3'd1,
    CFG_FRAME_HEIGHT = 3'd2,
    CFG_ROW_LENGTH   = 3'd3,
    CFG_POINT_SIZE   = 3'd4,
    CFG_SHADE_FACTOR = 3'd5,
    CFG_BACKGROUND   = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_reg_t;

  // color modes
  localparam logic [2:0] MODE_HEIGHT    = 3'd0;
  localparam logic [2:0] MODE_INTENSITY = 3'd2;
  localparam logic [2:0] MODE_MIX       = 3'd4;

  // register reset values
  localparam logic [2:0]  RST_COLOR_MODE   = 3'd1;
  localparam logic [11:0] RST_FRAME_SIZE   = 12'd2048;
  localparam logic [2:0]  RST_POINT_SIZE   = 3'd1;
  localparam logic [31:0] RST_SHADE_FACTOR = 32'd11621769;
  localparam logic [31:0] RST_BACKGROUND   = 32'd0;

  // index arithmetic constants
  localparam logic [31:0] PALETTE_MASK = 32'hFF00;
  localparam logic [31:0] VALUE_MASK   = 32'hFF;
  localparam int          HEIGHT_SHIFT = 16;
  localparam logic [7:0]  VALUE_SAT    = 8'd255;

  // request to the shading unit
  typedef struct packed {
    logic [31:0] diff;
    logic [31:0] gain;
    logic [31:0] depth;
    logic [7:0]  base;
  } shade_req_t;

endpackage

`default_nettype wire

// ===== design/depth_splat_min_filter_shade_unit.sv =====
// depth_splat_min_filter_shade_unit: top level, sequencer, config registers, stores
// depends on dsmfs_pkg, dsmfs_ram and dsmfs_shade
`default_nettype none

// Point-size post-process over a raster stream of {depth, attribute} words. Each pixel
// takes one input beat. A skipped border pixel goes through the accepting state, P-1 raw
// ring reads on the single read port, a wait to take the last read, then the update (no
// reads when P is one). A produced pixel goes on from there: the minimum over the P column
// minima is searched one entry a cycle and the shading term is a 32x32 multiply, a range
// check and a nine-step restoring division; the division is skipped when the term
// saturates, no shading is done for an empty window, and the result waits for a free
// output register. The raw row ring (MAX_POINT_SIZE-1 rows) and the filtered row sit in
// memories with no clearing pass; the column minima are flops that reset to all ones.
// The input is accepted only between pixels; a finished result waits in the output
// register while the next beat is taken.
module depth_splat_min_filter_shade_unit #(
  parameter int MAX_POINT_SIZE = dsmfs_pkg::DEF_MAX_POINT_SIZE,
  parameter int MAX_ROW_LENGTH = dsmfs_pkg::DEF_MAX_ROW_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // depth[31:0], attribute[63:32]
  input  wire logic [0:0]  s_axis_tuser,  // frame_start[0]
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // out_x[10:0], out_y[21:11], pixel_value[53:22]
  output logic [1:0]       m_axis_tuser,  // is_background[0], table_select[1]
  output logic             m_axis_tlast   // frame_done
);

  localparam int RING_ROWS = (MAX_POINT_SIZE > 1) ? MAX_POINT_SIZE - 1 : 1;
  localparam int RAW_DEPTH = RING_ROWS * MAX_ROW_LENGTH;
  localparam int RAW_AW    = $clog2(RAW_DEPTH);
  localparam int COL_W     = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W     = $clog2(MAX_ROW_LENGTH + 1);
  localparam int SLOT_W    = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;
  localparam int P_W       = $clog2(MAX_POINT_SIZE + 1);
  localparam int IDX_W     = (MAX_POINT_SIZE > 1) ? $clog2(MAX_POINT_SIZE) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MIN  = 7'b0001000,
    S_CALC = 7'b0010000,
    S_WAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0]  color_mode;
  logic [11:0] frame_width, frame_height, row_length;
  logic [2:0]  point_size;
  logic [31:0] shade_factor, background_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode       <= dsmfs_pkg::RST_COLOR_MODE;
      frame_width      <= dsmfs_pkg::RST_FRAME_SIZE;
      frame_height     <= dsmfs_pkg::RST_FRAME_SIZE;
      row_length       <= dsmfs_pkg::RST_FRAME_SIZE;
      point_size       <= dsmfs_pkg::RST_POINT_SIZE;
      shade_factor     <= dsmfs_pkg::RST_SHADE_FACTOR;
      background_color <= dsmfs_pkg::RST_BACKGROUND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dsmfs_pkg::cfg_reg_t'(cfg_index))
        dsmfs_pkg::CFG_COLOR_MODE:   color_mode       <= cfg_data[2:0];
        dsmfs_pkg::CFG_FRAME_WIDTH:  frame_width      <= cfg_data[11:0];
        dsmfs_pkg::CFG_FRAME_HEIGHT: frame_height     <= cfg_data[11:0];
        dsmfs_pkg::CFG_ROW_LENGTH:   row_length       <= cfg_data[11:0];
        dsmfs_pkg::CFG_POINT_SIZE:   point_size       <= cfg_data[2:0];
        dsmfs_pkg::CFG_SHADE_FACTOR: shade_factor     <= cfg_data;
        dsmfs_pkg::CFG_BACKGROUND:   background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position and per-pixel context
  logic [COL_W-1:0]  column_count, cur_c, cur_xa;
  logic [10:0]       row_count, cur_r, cur_x, cur_y;
  logic [SLOT_W-1:0] ring_slot, cur_slot, rslot;
  logic [P_W-1:0]    cur_p, rk, mk;
  logic [LEN_W-1:0]  cur_len;
  logic [63:0]       word, colmin, top, bz;
  logic              pend, fdone;
  logic [31:0]       left_filtered_depth;
  logic [63:0]       column_minima [MAX_POINT_SIZE];

  // results waiting for the output register
  logic [31:0] res_pix;
  logic        res_bg, res_tsel;

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(RING_ROWS - 1) : s - SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_ROWS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // values seen at the accepting edge
  logic              fs, in_acc;
  logic [COL_W-1:0]  c_now;
  logic [10:0]       r_now;
  logic [SLOT_W-1:0] slot_now;
  logic [LEN_W-1:0]  len_now;
  logic [P_W-1:0]    p_now;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fs            = s_axis_tuser[0];
  assign c_now         = fs ? '0 : column_count;
  assign r_now         = fs ? '0 : row_count;
  assign slot_now      = fs ? '0 : ring_slot;

  always_comb begin
    if (row_length == 12'd0 || 32'(row_length) > MAX_ROW_LENGTH) begin
      len_now = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_now = LEN_W'(row_length);
    end
    if (32'(point_size) > MAX_POINT_SIZE) begin
      p_now = P_W'(MAX_POINT_SIZE);
    end else begin
      p_now = P_W'(point_size);
    end
  end

  // window geometry of the current pixel
  logic signed [15:0] x_s, y_s, w_s, h_s, p_s, xmax_a, xmax_b, xmax;
  logic               produce, fd_now;

  always_comb begin
    p_s    = $signed(16'(cur_p));
    x_s    = $signed(16'(cur_c)) - p_s + 16'sd1;
    y_s    = $signed(16'(cur_r)) - p_s + 16'sd1;
    w_s    = (32'(frame_width) > dsmfs_pkg::FRAME_LIMIT) ?
             16'sd2048 : $signed(16'(frame_width));
    h_s    = (32'(frame_height) > dsmfs_pkg::FRAME_LIMIT) ?
             16'sd2048 : $signed(16'(frame_height));
    xmax_a = w_s - p_s - 16'sd1;
    xmax_b = $signed(16'(cur_len)) - p_s;
    xmax   = (xmax_b < xmax_a) ? xmax_b : xmax_a;
    produce = (cur_p != '0) && (x_s >= 16'sd1) && (y_s >= 16'sd1) &&
              (x_s < w_s - p_s) && (y_s < h_s - p_s);
    fd_now  = (x_s == xmax) && (y_s == h_s - p_s - 16'sd1);
  end

  // raw row ring memory
  logic              raw_re;
  logic [RAW_AW-1:0] raw_raddr, raw_waddr;
  logic [63:0]       raw_rdata;

  assign raw_re    = (state == S_RD) && (rk < cur_p);
  assign raw_raddr = RAW_AW'(32'(rslot) * MAX_ROW_LENGTH) + RAW_AW'(cur_c);
  assign raw_waddr = RAW_AW'(32'(cur_slot) * MAX_ROW_LENGTH) + RAW_AW'(cur_c);

  dsmfs_ram #(
    .WIDTH(64),
    .DEPTH(RAW_DEPTH),
    .AW   (RAW_AW)
  ) u_raw (
    .clk  (clk),
    .we   (state == S_UPD),
    .waddr(raw_waddr),
    .wdata(word),
    .re   (raw_re),
    .raddr(raw_raddr),
    .rdata(raw_rdata)
  );

  // filtered row memory
  logic             filt_we;
  logic [COL_W-1:0] filt_waddr;
  logic [31:0]      filt_wdata, filt_rdata;
  logic [31:0]      mv;

  assign mv         = bz[63:32];
  assign filt_we    = ((state == S_UPD) && (cur_r == 11'd0)) || (state == S_CALC);
  assign filt_waddr = (state == S_CALC) ? cur_xa : cur_c;
  assign filt_wdata = (state == S_CALC) ? mv : word[63:32];

  dsmfs_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ROW_LENGTH),
    .AW   (COL_W)
  ) u_filt (
    .clk  (clk),
    .we   (filt_we),
    .waddr(filt_waddr),
    .wdata(filt_wdata),
    .re   (state == S_MIN),
    .raddr(cur_xa),
    .rdata(filt_rdata)
  );

  // shading request built from the filtered word
  logic                  shd_start, shd_done;
  dsmfs_pkg::shade_req_t shd_req;
  logic [7:0]            shd_val;
  logic [31:0]           bzs, pmask, vmask, ud, ld;
  logic                  tsel_now, bg_now;

  always_comb begin
    pmask    = dsmfs_pkg::PALETTE_MASK;
    vmask    = dsmfs_pkg::VALUE_MASK;
    tsel_now = 1'b0;
    bzs      = bz[31:0];
    if (color_mode == dsmfs_pkg::MODE_HEIGHT) begin
      tsel_now = 1'b1;
      vmask    = '0;
      bzs      = bz[dsmfs_pkg::HEIGHT_SHIFT +: 32];
    end else if (color_mode == dsmfs_pkg::MODE_INTENSITY) begin
      pmask = '0;
    end else if (color_mode == dsmfs_pkg::MODE_MIX) begin
      pmask = '0;
      vmask = '0;
    end
    bg_now = (bz == '1);
    ud = (filt_rdata > mv) ? filt_rdata - mv : mv - filt_rdata;
    ld = (left_filtered_depth > mv) ? left_filtered_depth - mv : mv - left_filtered_depth;
    shd_req.diff  = (ld > ud) ? ld : ud;
    shd_req.gain  = shade_factor;
    shd_req.depth = mv;
    shd_req.base  = 8'(bzs & vmask);
  end

  assign shd_start = (state == S_CALC) && !bg_now;

  dsmfs_shade u_shade (
    .clk  (clk),
    .rst  (rst),
    .start(shd_start),
    .req  (shd_req),
    .done (shd_done),
    .val  (shd_val)
  );

  logic out_load;
  assign out_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // pixel sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      column_count        <= '0;
      row_count           <= '0;
      ring_slot           <= '0;
      left_filtered_depth <= '0;
      pend                <= 1'b0;
      for (int i = 0; i < MAX_POINT_SIZE; i++) begin
        column_minima[i] <= '1;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            word     <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
            colmin   <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
            top      <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
            cur_c    <= c_now;
            cur_r    <= r_now;
            cur_slot <= slot_now;
            cur_p    <= p_now;
            cur_len  <= len_now;
            rslot    <= slot_dec(slot_now);
            rk       <= P_W'(1);
            pend     <= 1'b0;
            state    <= (p_now > P_W'(1)) ? S_RD : S_UPD;
            // advance the raster position
            if ({1'b0, LEN_W'(c_now)} + (LEN_W + 1)'(1) >= {1'b0, len_now}) begin
              column_count <= '0;
              if (r_now < dsmfs_pkg::ROW_HOLD) begin
                row_count <= r_now + 11'd1;
                ring_slot <= slot_inc(slot_now);
              end else begin
                row_count <= r_now;
                ring_slot <= slot_now;
              end
            end else begin
              column_count <= c_now + COL_W'(1);
              row_count    <= r_now;
              ring_slot    <= slot_now;
            end
          end
        end
        S_RD: begin
          // one ring read issued and one consumed per cycle
          if (raw_re) begin
            rslot <= slot_dec(rslot);
            rk    <= rk + P_W'(1);
          end
          pend <= raw_re;
          if (pend) begin
            if (raw_rdata < colmin) begin
              colmin <= raw_rdata;
            end
            top <= raw_rdata;
          end
          if (!raw_re) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (cur_p != '0) begin
            for (int i = MAX_POINT_SIZE - 1; i > 0; i--) begin
              column_minima[i] <= column_minima[i-1];
            end
            column_minima[0] <= colmin;
            if (cur_c == '0) begin
              left_filtered_depth <= top[63:32];
            end
          end
          cur_xa <= COL_W'(x_s);
          cur_x  <= 11'(x_s);
          cur_y  <= 11'(y_s);
          fdone  <= fd_now;
          bz     <= colmin;
          mk     <= P_W'(1);
          state  <= produce ? S_MIN : S_IDLE;
        end
        S_MIN: begin
          // window minimum over the column minima, one a cycle
          if (mk < cur_p) begin
            if (column_minima[mk[IDX_W-1:0]] < bz) begin
              bz <= column_minima[mk[IDX_W-1:0]];
            end
            mk <= mk + P_W'(1);
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          left_filtered_depth <= mv;
          res_tsel            <= bg_now ? 1'b0 : tsel_now;
          res_bg              <= bg_now;
          if (bg_now) begin
            res_pix <= background_color;
            state   <= S_EMIT;
          end else begin
            res_pix <= pmask & bzs;
            state   <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (shd_done) begin
            res_pix <= res_pix + 32'(shd_val);
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b00, res_pix, cur_y, cur_x};
      m_axis_tuser <= {res_tsel, res_bg};
      m_axis_tlast <= fdone;
    end
  end

  // checks
  a_shade_only_waiting: assert property (@(posedge clk) disable iff (rst)
    shd_done |-> (state == S_WAIT))
    else $error("shading result outside wait state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  a_ring_reads_need_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (cur_p > P_W'(1)))
    else $error("ring read with window of one");

endmodule

`default_nettype wire

// ===== design/dsmfs_ram.sv =====
// dsmfs_ram: simple dual port synchronous memory, one write and one registered read
// uses no package items
`default_nettype none

module dsmfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dsmfs_shade.sv =====
// dsmfs_shade: shading term, multiply then saturating restoring division
// depends on dsmfs_pkg for the request struct and saturation value
`default_nettype none

module dsmfs_shade (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire dsmfs_pkg::shade_req_t req,
  output logic                       done,
  output logic [7:0]                 val
);

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MUL  = 5'b00010,
    H_CHK  = 5'b00100,
    H_DIV  = 5'b01000,
    H_FIN  = 5'b10000
  } hstate_t;

  hstate_t           state;
  dsmfs_pkg::shade_req_t r;
  logic [63:0]       prod;
  logic [48:0]       rem;
  logic [47:0]       dsh;
  logic [8:0]        quo;
  logic [3:0]        bitn;
  logic              sat;
  logic [9:0]        sum;

  assign sum = {2'b00, r.base} + {1'b0, quo};

  // sequencer: multiply, range check, nine quotient bits, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            r     <= req;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          prod  <= 64'(r.diff) * 64'(r.gain);
          state <= H_CHK;
        end
        H_CHK: begin
          quo <= '0;
          if (r.depth == 32'd0 || prod >= {15'd0, r.depth, 17'd0}) begin
            sat   <= 1'b1;
            state <= H_FIN;
          end else begin
            sat   <= 1'b0;
            rem   <= prod[48:0];
            dsh   <= {r.depth, 16'd0};
            bitn  <= 4'd8;
            state <= H_DIV;
          end
        end
        H_DIV: begin
          if (rem >= {1'b0, dsh}) begin
            rem       <= rem - {1'b0, dsh};
            quo[bitn] <= 1'b1;
          end
          dsh <= dsh >> 1;
          if (bitn == 4'd0) begin
            state <= H_FIN;
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        H_FIN: begin
          if (sat || sum > 10'(dsmfs_pkg::VALUE_SAT)) begin
            val <= dsmfs_pkg::VALUE_SAT;
          end else begin
            val <= sum[7:0];
          end
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
